/* hw/rtl/mmss_pkg.sv */
package mmss_pkg;

   // Store geometry
   localparam int MAP_WORDS     = 4096;
   localparam int MAP_AW        = $clog2(MAP_WORDS);
   localparam int LAYERS        = 4;
   localparam int LAYER_W       = 2;
   localparam int MAP_MEM_WORDS = LAYERS * MAP_WORDS;
   localparam int MAP_MEM_AW    = LAYER_W + MAP_AW;
   localparam int TILESET_WORDS = 4096;
   localparam int TILE_AW       = $clog2(TILESET_WORDS);
   localparam int WORD_W        = 16;

   // Command fields
   localparam int LOAD_AW           = 12;
   localparam int POS_W             = 8;
   localparam int SCROLL_W          = 19;
   localparam int SCROLL_FRAC_SHIFT = 11;
   localparam int START_W           = SCROLL_W - SCROLL_FRAC_SHIFT;
   localparam int T_W               = START_W + 1;

   // Strip and screen block
   localparam int STRIP_LEN   = 32;
   localparam int IDX_W       = $clog2(STRIP_LEN);
   localparam int SCREEN_BITS = 5;
   localparam int SIDX_W      = 2 * SCREEN_BITS;

   // Configuration
   localparam int MAPW_W = 8;
   localparam int CSR_DW = 8;
   localparam int CSR_IW = 1;
   localparam logic [CSR_IW-1:0] CSR_MAP_WIDTH = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_ENABLE    = 1'b1;
   localparam logic [MAPW_W-1:0] MAP_WIDTH_RESET = 8'd64;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;
   localparam int CRED_W     = FIFO_CW + 1;

   typedef enum logic [1:0] {
      CMD_LOAD_MAP  = 2'd0,
      CMD_LOAD_TILE = 2'd1,
      CMD_DRAW_ROW  = 2'd2,
      CMD_DRAW_COL  = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_ISSUE
   } seq_state_type;

   typedef struct packed {
      logic [LAYER_W-1:0] screen_block;
      logic [SIDX_W-1:0]  screen_index;
      logic               last;
   } strip_info_type;

   typedef struct packed {
      logic                  valid;
      logic [MAP_MEM_AW-1:0] map_addr;
      logic [1:0]            sub;
      strip_info_type        info;
   } map_req_type;

   typedef struct packed {
      logic                  map_we;
      logic                  tile_we;
      logic [MAP_MEM_AW-1:0] map_addr;
      logic [TILE_AW-1:0]    tile_addr;
      logic [WORD_W-1:0]     data;
   } store_wr_type;

   typedef struct packed {
      logic b_valid;
      logic c_valid;
   } pipe_status_type;

   typedef struct packed {
      logic [LAYER_W-1:0] screen_block;
      logic [SIDX_W-1:0]  screen_index;
      logic [WORD_W-1:0]  screen_entry;
      logic               last;
   } rsp_item_type;

   function automatic logic layer_in_range(input logic [LAYER_W-1:0] layer);
      return ({1'b0, layer} < (LAYER_W + 1)'(LAYERS));
   endfunction

endpackage

/* hw/rtl/mmss_if.sv */
interface mmss_req_if import mmss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [LAYER_W-1:0]  layer;
   logic [LOAD_AW-1:0]  load_address;
   logic [WORD_W-1:0]   load_value;
   logic [POS_W-1:0]    strip_pos;
   logic [SCROLL_W-1:0] scroll_fixed;

   modport source (output valid, cmd, layer, load_address, load_value, strip_pos,
                   scroll_fixed, input ready);
   modport sink   (input valid, cmd, layer, load_address, load_value, strip_pos,
                   scroll_fixed, output ready);
endinterface

interface mmss_rsp_if import mmss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LAYER_W-1:0] screen_block;
   logic [SIDX_W-1:0]  screen_index;
   logic [WORD_W-1:0]  screen_entry;
   logic               last;

   modport source (output valid, screen_block, screen_index, screen_entry, last,
                   input ready);
   modport sink   (input valid, screen_block, screen_index, screen_entry, last,
                   output ready);
endinterface

/* hw/rtl/metatile_map_strip_streamer.sv */
// Metatile map strip streamer. Load commands write one word into a layer's
// metatile map or into the shared tileset. A draw-row or draw-column command
// is followed by 32 screen entries, one per cycle while the result side takes
// them: each entry needs an address stage (one multiply by map_width), a read
// of the map memory and then a dependent read of the tileset memory. A draw
// occupies the block (setup, the issue of all 32 entries, then the 3-stage
// read pipeline) before the next command is taken; a stall on rsp_ch holds
// it up. An 8-entry result queue lets the read pipeline keep going while
// results wait. Both memories come up undefined after reset; load every map
// and tileset word a draw will touch before drawing. Configuration registers
// (map_width at index 0, engine_enabled at index 1) are written via csr_we
// and must only change while no draw is in progress.
module metatile_map_strip_streamer import mmss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   mmss_req_if.sink          req_ch,
   mmss_rsp_if.source        rsp_ch
);

   logic [MAPW_W-1:0] map_width_ff;
   logic              enable_ff;

   logic               accept;
   cmd_type            req_cmd;
   logic               layer_ok;
   logic               is_draw;
   logic               start_draw;
   logic               credit_ok;
   logic               issue_idle;
   map_req_type        map_req;
   store_wr_type       wr;
   pipe_status_type    status;
   logic               push;
   rsp_item_type       push_item;
   rsp_item_type       out_item;
   logic               out_valid;
   logic [FIFO_CW-1:0] fifo_count;
   logic [CRED_W-1:0]  pending;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff <= MAP_WIDTH_RESET;
         enable_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH: map_width_ff <= csr_wdata[MAPW_W-1:0];
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   assign accept     = req_ch.valid && req_ch.ready;
   assign req_cmd    = cmd_type'(req_ch.cmd);
   assign layer_ok   = layer_in_range(req_ch.layer);
   assign is_draw    = (req_cmd == CMD_DRAW_ROW) || (req_cmd == CMD_DRAW_COL);
   assign start_draw = accept && is_draw && layer_ok && enable_ff;

   always_comb begin
      wr.map_we    = accept && (req_cmd == CMD_LOAD_MAP) && layer_ok;
      wr.tile_we   = accept && (req_cmd == CMD_LOAD_TILE);
      wr.map_addr  = {req_ch.layer, MAP_AW'(req_ch.load_address)};
      wr.tile_addr = TILE_AW'(req_ch.load_address);
      wr.data      = req_ch.load_value;
   end

   // only issue when the queue can absorb everything already in the read pipe
   assign pending   = CRED_W'(fifo_count) + CRED_W'(map_req.valid)
                    + CRED_W'(status.b_valid) + CRED_W'(status.c_valid);
   assign credit_ok = (pending < CRED_W'(FIFO_DEPTH));

   // new command only once all reads of the previous draw are done
   assign req_ch.ready = issue_idle && !map_req.valid && !status.b_valid
                       && !status.c_valid;

   mmss_issue u_issue (
      .clock        (clock),
      .reset        (reset),
      .start_draw   (start_draw),
      .draw_row     (req_cmd == CMD_DRAW_ROW),
      .layer        (req_ch.layer),
      .strip_pos    (req_ch.strip_pos),
      .scroll_fixed (req_ch.scroll_fixed),
      .map_width    (map_width_ff),
      .credit_ok    (credit_ok),
      .map_req      (map_req),
      .idle         (issue_idle)
   );

   mmss_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .map_req   (map_req),
      .status    (status),
      .push      (push),
      .push_item (push_item)
   );

   mmss_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (out_valid && rsp_ch.ready),
      .out_valid (out_valid),
      .out_item  (out_item),
      .count     (fifo_count)
   );

   assign rsp_ch.valid        = out_valid;
   assign rsp_ch.screen_block = out_item.screen_block;
   assign rsp_ch.screen_index = out_item.screen_index;
   assign rsp_ch.screen_entry = out_item.screen_entry;
   assign rsp_ch.last         = out_item.last;

endmodule

/* hw/rtl/mmss_issue.sv */
module mmss_issue import mmss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start_draw,
   input  logic                draw_row,
   input  logic [LAYER_W-1:0]  layer,
   input  logic [POS_W-1:0]    strip_pos,
   input  logic [SCROLL_W-1:0] scroll_fixed,
   input  logic [MAPW_W-1:0]   map_width,
   input  logic                credit_ok,
   output map_req_type         map_req,
   output logic                idle
);

   seq_state_type state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               row_ff;
   logic [LAYER_W-1:0] layer_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [START_W-1:0] start_ff;
   map_req_type        req_ff, req_in;

   logic                      fire;
   logic                      last_idx;
   logic [T_W-1:0]            t;
   logic [START_W-1:0]        t_half;
   logic [START_W-1:0]        pos_half;
   logic [START_W-1:0]        mul_a;
   logic [START_W-1:0]        addend;
   logic [START_W+MAPW_W-1:0] prod;
   logic [MAP_AW-1:0]         madr;

   assign last_idx = (idx_ff == IDX_W'(STRIP_LEN - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start_draw) state_in = ST_ISSUE;
         ST_ISSUE: if (fire && last_idx) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fire = 1'b0;
      idle = 1'b0;
      case (state_ff)
         ST_IDLE:  idle = 1'b1;
         ST_ISSUE: fire = credit_ok;
         default:  idle = 1'b1;
      endcase
   end

   // tile coordinate along the strip, then the map address (one multiply)
   assign t        = {1'b0, start_ff} + T_W'(idx_ff);
   assign t_half   = t[T_W-1:1];
   assign pos_half = START_W'(pos_ff[POS_W-1:1]);
   assign mul_a    = row_ff ? pos_half : t_half;
   assign addend   = row_ff ? t_half : pos_half;
   assign prod     = mul_a * map_width;
   assign madr     = prod[MAP_AW-1:0] + MAP_AW'(addend);

   always_comb begin
      req_in.valid                   = fire;
      req_in.map_addr                = {layer_ff, madr};
      req_in.info.screen_block       = layer_ff;
      req_in.info.last               = last_idx;
      if (row_ff) begin
         req_in.sub                  = {pos_ff[0], t[0]};
         req_in.info.screen_index    = {pos_ff[SCREEN_BITS-1:0], t[SCREEN_BITS-1:0]};
      end else begin
         req_in.sub                  = {t[0], pos_ff[0]};
         req_in.info.screen_index    = {t[SCREEN_BITS-1:0], pos_ff[SCREEN_BITS-1:0]};
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (start_draw)
         idx_in = '0;
      else if (fire)
         idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      req_ff.map_addr <= req_in.map_addr;
      req_ff.sub      <= req_in.sub;
      req_ff.info     <= req_in.info;
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         req_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         req_ff.valid <= req_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (start_draw) begin
         row_ff   <= draw_row;
         layer_ff <= layer;
         pos_ff   <= strip_pos;
         start_ff <= scroll_fixed[SCROLL_W-1:SCROLL_FRAC_SHIFT];
      end
   end

   assign map_req = req_ff;

endmodule

/* hw/rtl/mmss_store.sv */
module mmss_store import mmss_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  store_wr_type    wr,
   input  map_req_type     map_req,
   output pipe_status_type status,
   output logic            push,
   output rsp_item_type    push_item
);

   logic [WORD_W-1:0] map_mem  [MAP_MEM_WORDS];
   logic [WORD_W-1:0] tile_mem [TILESET_WORDS];

   // map read stage
   logic              b_valid_ff;
   logic [1:0]        b_sub_ff;
   strip_info_type    b_info_ff;
   logic [WORD_W-1:0] meta_ff;

   // tileset read stage
   logic              c_valid_ff;
   strip_info_type    c_info_ff;
   logic [WORD_W-1:0] entry_ff;

   logic [TILE_AW-1:0] tile_addr;

   always_ff @(posedge clock) begin
      if (wr.map_we)
         map_mem[wr.map_addr] <= wr.data;
      meta_ff <= map_mem[map_req.map_addr];
   end

   // tileset address wraps: four words per metatile
   assign tile_addr = {meta_ff[TILE_AW-3:0], b_sub_ff};

   always_ff @(posedge clock) begin
      if (wr.tile_we)
         tile_mem[wr.tile_addr] <= wr.data;
      entry_ff <= tile_mem[tile_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= map_req.valid;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_sub_ff  <= map_req.sub;
      b_info_ff <= map_req.info;
      c_info_ff <= b_info_ff;
   end

   assign status.b_valid = b_valid_ff;
   assign status.c_valid = c_valid_ff;

   assign push                   = c_valid_ff;
   assign push_item.screen_block = c_info_ff.screen_block;
   assign push_item.screen_index = c_info_ff.screen_index;
   assign push_item.screen_entry = entry_ff;
   assign push_item.last         = c_info_ff.last;

endmodule

/* hw/rtl/mmss_rsp_fifo.sv */
module mmss_rsp_fifo import mmss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_item_type       push_item,
   input  logic               pop,
   output logic               out_valid,
   output rsp_item_type       out_item,
   output logic [FIFO_CW-1:0] count
);

   rsp_item_type       slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_item;
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* hw/rtl/mmss_checker.sv */
module mmss_checker import mmss_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_cmd,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LAYER_W-1:0] rsp_screen_block,
   input logic [SIDX_W-1:0]  rsp_screen_index,
   input logic [WORD_W-1:0]  rsp_screen_entry,
   input logic               rsp_last
);

   logic load_xfer;

   assign load_xfer = req_valid && req_ready
                    && ((cmd_type'(req_cmd) == CMD_LOAD_MAP)
                        || (cmd_type'(req_cmd) == CMD_LOAD_TILE));

   // nothing queued comes out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a load never starts a draw, so the block is ready again at once
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      load_xfer |=> req_ready)
      else $error("not ready after a load transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_block)
         && $stable(rsp_screen_index) && $stable(rsp_screen_entry)
         && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind metatile_map_strip_streamer mmss_checker u_mmss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_cmd          (req_ch.cmd),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_screen_block (rsp_ch.screen_block),
   .rsp_screen_index (rsp_ch.screen_index),
   .rsp_screen_entry (rsp_ch.screen_entry),
   .rsp_last         (rsp_ch.last)
);
